// ===== hdl/dshotqmt_pkg.sv =====
`timescale 1ns / 1ps

package dshotqmt_pkg;

    // Lane count and pin vector width are fixed by the four throttle ports.
    localparam int MOTOR_COUNT = 4;
    localparam int CFG_W = 16;
    localparam int THROTTLE_W = 11;
    localparam int FRAME_W = 16;
    localparam int BIT_IDX_W = 4;

    localparam logic [THROTTLE_W-1:0] THROTTLE_MAX = 11'd1999;
    localparam logic [THROTTLE_W-1:0] THROTTLE_OFFSET = 11'd48;

    localparam logic [BIT_IDX_W-1:0] BIT_FIRST = 4'd15;
    localparam logic [BIT_IDX_W-1:0] BIT_LAST = 4'd0;

    // Item kinds.
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_COMMAND = 1'b1;

    // Register word indexes on the configuration port.
    localparam logic [1:0] REG_SHORT_PULSE = 2'd0;
    localparam logic [1:0] REG_LONG_PULSE = 2'd1;
    localparam logic [1:0] REG_BIT_PERIOD = 2'd2;

    // What the lanes need from the slot timer to resolve their pin level.
    typedef struct packed {
        logic                 sending;
        logic [BIT_IDX_W-1:0] bit_idx;
        logic                 ge_short;
        logic                 ge_long;
    } timer_view_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic accepted;
    } timer_status_t;

endpackage

// ===== hdl/dshot_quad_motor_transmitter_top.sv =====
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// input     in_valid / in_ready    req_type, throttle_*, telemetry_request
// result    out_valid / out_ready  motor_pins, busy_res, frame_done, accepted
// config    APB psel/penable       paddr[3:0], pwdata, prdata (16-bit registers)
//
// One item is taken every clock while in_ready is high; its result appears in
// the output register on the next cycle. The path from the slot counter through
// the pulse compares to the pin merge sets the cycle time. in_ready drops only
// while a result sits unclaimed and out_ready is low. Reset idles the timer and
// loads the default pulse and period counts.

module dshot_quad_motor_transmitter_top #(
    parameter int TICK_COUNTER_BITS = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic                                    req_type,
    input  logic [dshotqmt_pkg::THROTTLE_W-1:0]     throttle_front_left,
    input  logic [dshotqmt_pkg::THROTTLE_W-1:0]     throttle_front_right,
    input  logic [dshotqmt_pkg::THROTTLE_W-1:0]     throttle_back_left,
    input  logic [dshotqmt_pkg::THROTTLE_W-1:0]     throttle_back_right,
    input  logic                                    telemetry_request,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [dshotqmt_pkg::MOTOR_COUNT-1:0]    motor_pins,
    output logic                                    busy_res,
    output logic                                    frame_done,
    output logic                                    accepted,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [3:0]                              paddr,
    input  logic [31:0]                             pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready
);
    import dshotqmt_pkg::*;

    logic [CFG_W-1:0] short_reg;
    logic [CFG_W-1:0] long_reg;
    logic [CFG_W-1:0] period_reg;

    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [MOTOR_COUNT-1:0]  pins_reg;
    logic [MOTOR_COUNT-1:0]  pins_next;
    logic                    busy_reg;
    logic                    done_reg;
    logic                    accepted_reg;

    logic                    accept;
    logic                    cfg_write;
    logic [THROTTLE_W-1:0]   throttles [MOTOR_COUNT];
    timer_view_t             view;
    timer_status_t           status;

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_reg <= 16'd739;
            long_reg <= 16'd1489;
            period_reg <= 16'd1993;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_SHORT_PULSE: short_reg <= pwdata[CFG_W-1:0];
                REG_LONG_PULSE:  long_reg <= pwdata[CFG_W-1:0];
                REG_BIT_PERIOD:  period_reg <= pwdata[CFG_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_SHORT_PULSE: prdata = {16'd0, short_reg};
            REG_LONG_PULSE:  prdata = {16'd0, long_reg};
            REG_BIT_PERIOD:  prdata = {16'd0, period_reg};
            default:         prdata = 32'd0;
        endcase
    end

    assign in_ready = !out_valid_reg || out_ready;
    assign accept = in_valid && in_ready;

    dshotqmt_timer #(
        .TICK_COUNTER_BITS(TICK_COUNTER_BITS)
    ) u_timer (
        .clk(clk),
        .rst_n(rst_n),
        .accept(accept),
        .req_type(req_type),
        .short_pulse_ticks(short_reg),
        .long_pulse_ticks(long_reg),
        .bit_period_ticks(period_reg),
        .view(view),
        .status(status)
    );

    assign throttles[0] = throttle_front_left;
    assign throttles[1] = throttle_front_right;
    assign throttles[2] = throttle_back_left;
    assign throttles[3] = throttle_back_right;

    for (genvar m = 0; m < MOTOR_COUNT; m++)
    begin : g_lane
        dshotqmt_lane u_lane (
            .clk(clk),
            .load(accept && status.accepted),
            .throttle(throttles[m]),
            .telemetry_request(telemetry_request),
            .view(view),
            .pin(pins_next[m])
        );
    end

    always_comb
    begin
        if (accept)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pins_reg <= pins_next;
            busy_reg <= status.busy;
            done_reg <= status.done;
            accepted_reg <= status.accepted;
        end
    end

    assign out_valid = out_valid_reg;
    assign motor_pins = pins_reg;
    assign busy_res = busy_reg;
    assign frame_done = done_reg;
    assign accepted = accepted_reg;

endmodule

// ===== hdl/dshotqmt_lane.sv =====
`timescale 1ns / 1ps

module dshotqmt_lane (
    input  logic                                clk,
    input  logic                                load,
    input  logic [dshotqmt_pkg::THROTTLE_W-1:0] throttle,
    input  logic                                telemetry_request,
    input  dshotqmt_pkg::timer_view_t           view,
    output logic                                pin
);
    import dshotqmt_pkg::*;

    logic [FRAME_W-1:0]    frame_reg;
    logic [FRAME_W-1:0]    frame_next;
    logic [FRAME_W-1:0]    frame_built;
    logic [FRAME_W-1:0]    frame_view;
    logic [THROTTLE_W-1:0] value;
    logic [11:0]           packet;
    logic [3:0]            crc;
    logic                  cur_bit;

    always_comb
    begin
        value = (throttle > THROTTLE_MAX) ? THROTTLE_MAX : throttle;
        value = value + THROTTLE_OFFSET;
        packet = {value, telemetry_request};
        crc = packet[3:0] ^ packet[7:4] ^ packet[11:8];
        frame_built = {packet, crc};
    end

    // A freshly loaded frame is already visible on the item that loads it.
    assign frame_view = load ? frame_built : frame_reg;
    assign frame_next = frame_view;
    assign cur_bit = frame_view[view.bit_idx];
    assign pin = view.sending && !(view.ge_long || (!cur_bit && view.ge_short));

    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
    end

endmodule

// ===== hdl/dshotqmt_timer.sv =====
`timescale 1ns / 1ps

module dshotqmt_timer #(
    parameter int TICK_COUNTER_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             accept,
    input  logic                             req_type,
    input  logic [dshotqmt_pkg::CFG_W-1:0]   short_pulse_ticks,
    input  logic [dshotqmt_pkg::CFG_W-1:0]   long_pulse_ticks,
    input  logic [dshotqmt_pkg::CFG_W-1:0]   bit_period_ticks,
    output dshotqmt_pkg::timer_view_t        view,
    output dshotqmt_pkg::timer_status_t      status
);
    import dshotqmt_pkg::*;

    localparam int CmpW = ((TICK_COUNTER_BITS > CFG_W) ? TICK_COUNTER_BITS : CFG_W) + 1;

    logic [TICK_COUNTER_BITS-1:0] count_reg;
    logic [TICK_COUNTER_BITS-1:0] count_next;
    logic [BIT_IDX_W-1:0]         bit_idx_reg;
    logic [BIT_IDX_W-1:0]         bit_idx_next;
    logic                         sending_reg;
    logic                         sending_next;

    logic                         load;
    logic [TICK_COUNTER_BITS-1:0] count_view;
    logic [CmpW-1:0]              count_view_ext;
    logic [CmpW-1:0]              count_inc;
    logic [CmpW-1:0]              short_ext;
    logic [CmpW-1:0]              long_ext;
    logic [CmpW-1:0]              period_ext;
    logic                         slot_end;

    assign load = (req_type == REQ_COMMAND) && !sending_reg;

    always_comb
    begin
        count_view = load ? '0 : count_reg;
        count_view_ext = {{(CmpW-TICK_COUNTER_BITS){1'b0}}, count_view};
        count_inc = {{(CmpW-TICK_COUNTER_BITS){1'b0}}, count_reg} + CmpW'(1);
        short_ext = {{(CmpW-CFG_W){1'b0}}, short_pulse_ticks};
        long_ext = {{(CmpW-CFG_W){1'b0}}, long_pulse_ticks};
        period_ext = {{(CmpW-CFG_W){1'b0}}, bit_period_ticks};
        // With a zero period slot_end is always true, so each tick item ends the slot.
        slot_end = (count_inc >= period_ext);

        view.sending = load || sending_reg;
        view.bit_idx = load ? BIT_FIRST : bit_idx_reg;
        view.ge_short = (count_view_ext >= short_ext);
        view.ge_long = (count_view_ext >= long_ext);

        status.busy = (req_type == REQ_COMMAND) ? 1'b1 : sending_reg;
        status.done = (req_type == REQ_TICK) && sending_reg && slot_end
                      && (bit_idx_reg == BIT_LAST);
        status.accepted = load;
    end

    always_comb
    begin
        count_next = count_reg;
        bit_idx_next = bit_idx_reg;
        sending_next = sending_reg;
        if (accept)
        begin
            if (load)
            begin
                count_next = '0;
                bit_idx_next = BIT_FIRST;
                sending_next = 1'b1;
            end
            else if ((req_type == REQ_TICK) && sending_reg)
            begin
                if (slot_end)
                begin
                    count_next = '0;
                    if (bit_idx_reg == BIT_LAST)
                    begin
                        sending_next = 1'b0;
                        bit_idx_next = BIT_FIRST;
                    end
                    else
                    begin
                        bit_idx_next = bit_idx_reg - 1'b1;
                    end
                end
                else
                begin
                    count_next = count_inc[TICK_COUNTER_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            bit_idx_reg <= BIT_FIRST;
            sending_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            bit_idx_reg <= bit_idx_next;
            sending_reg <= sending_next;
        end
    end

    a_done_stops: assert property (@(posedge clk) disable iff (!rst_n)
        accept && status.done |=> !sending_reg && (bit_idx_reg == BIT_FIRST))
        else $error("frame end did not return the timer to idle");

    a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && status.accepted |=> sending_reg && (bit_idx_reg == BIT_FIRST)
                                       && (count_reg == '0))
        else $error("accepted command did not start a frame at slot zero");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !sending_reg |-> (count_reg == '0) && (bit_idx_reg == BIT_FIRST))
        else $error("idle timer holds a stale slot position");

    a_refuse_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (req_type == REQ_COMMAND) && sending_reg
        |=> $stable(bit_idx_reg) && $stable(count_reg) && sending_reg)
        else $error("refused command disturbed the frame in flight");

endmodule
